@@ rtl/flc_pkg.sv @@
// Shared types and constants for the fader level deadzone coalescer.
// Used by flc_level, flc_lane and the top level; depends on nothing else.
`default_nettype none

package flc_pkg;

  localparam int CHANNELS_DEF = 11;
  localparam int SAMPLES_DEF  = 8;
  localparam int MAX_SAMPLES  = 8;

  localparam int CH_W    = 4;
  localparam int TIME_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int LEVEL_W = 7;
  localparam int DZ_W    = 7;
  localparam int ES_W    = 6;
  localparam int QUIET_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam longint unsigned FULL_SCALE = 65535;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  localparam logic [DZ_W-1:0]    DEADZONE_RST = 7'd2;
  localparam logic [ES_W-1:0]    ENDSTOP_RST  = 6'd1;
  localparam logic [QUIET_W-1:0] QUIET_RST    = 16'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE = 2'd0,
    REG_ENDSTOP  = 2'd1,
    REG_QUIET    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_ms;
    logic [SAMP_W-1:0] sample_0;
    logic [SAMP_W-1:0] sample_1;
    logic [SAMP_W-1:0] sample_2;
    logic [SAMP_W-1:0] sample_3;
    logic [SAMP_W-1:0] sample_4;
    logic [SAMP_W-1:0] sample_5;
    logic [SAMP_W-1:0] sample_6;
    logic [SAMP_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic [LEVEL_W-1:0] level_pct;
  } out_item_t;

  typedef struct packed {
    logic [DZ_W-1:0]    deadzone_pct;
    logic [ES_W-1:0]    endstop_pct;
    logic [QUIET_W-1:0] quiet_ms;
  } cfg_t;

  // A scaled reading as it leaves the level pipeline.
  typedef struct packed {
    logic               valid;
    logic [CH_W-1:0]    channel;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] pct;
  } stage_t;

  typedef struct packed {
    logic               emit;
    logic [LEVEL_W-1:0] level;
  } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/flc_level.sv @@
// Three-stage pipeline that sums the ADC reads, scales them to a percent and snaps the endstops.
// Depends on flc_pkg.
`default_nettype none

module flc_level #(
  parameter int SAMPLES = flc_pkg::SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire flc_pkg::in_item_t item,
  input  wire flc_pkg::cfg_t     cfg,
  output flc_pkg::stage_t        stage,
  input  wire logic             take
);
  import flc_pkg::*;

  localparam int SUM_W = SAMP_W + $clog2(SAMPLES);
  localparam int X_W   = SUM_W + LEVEL_W;
  localparam int P_W   = SUM_W + 8;
  localparam longint unsigned DIV   = longint'(SAMPLES) * FULL_SCALE;
  // floor(100 * 2^SUM_W / DIV): the estimate is exact or one too small.
  localparam longint unsigned RECIP = (longint'(100) << SUM_W) / DIV;
  localparam logic [X_W-1:0] DIV_V     = X_W'(DIV);
  localparam logic [X_W-1:0] HUNDRED_V = X_W'(100);
  localparam logic [P_W-1:0] RECIP_V   = P_W'(RECIP);

  logic [SAMP_W-1:0] samp [MAX_SAMPLES];
  logic [SUM_W-1:0]  sum_next;

  logic              s1_valid;
  logic [CH_W-1:0]   s1_channel;
  logic [TIME_W-1:0] s1_now;
  logic [SUM_W-1:0]  s1_sum;

  logic               s2_valid;
  logic [CH_W-1:0]    s2_channel;
  logic [TIME_W-1:0]  s2_now;
  logic [SUM_W-1:0]   s2_sum;
  logic [LEVEL_W-1:0] s2_est;

  logic               s3_valid;
  logic [CH_W-1:0]    s3_channel;
  logic [TIME_W-1:0]  s3_now;
  logic [LEVEL_W-1:0] s3_pct;

  logic               s1_free, s2_free, s3_free;
  logic [P_W-1:0]     prod;
  logic [LEVEL_W-1:0] est_next;
  logic [X_W-1:0]     scaled;
  logic [X_W-1:0]     bound;
  logic [LEVEL_W-1:0] est_inc;
  logic [LEVEL_W-1:0] quot;
  logic [LEVEL_W-1:0] pct_next;

  assign samp[0] = item.sample_0;
  assign samp[1] = item.sample_1;
  assign samp[2] = item.sample_2;
  assign samp[3] = item.sample_3;
  assign samp[4] = item.sample_4;
  assign samp[5] = item.sample_5;
  assign samp[6] = item.sample_6;
  assign samp[7] = item.sample_7;

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < SAMPLES; k++) begin
      sum_next = sum_next + SUM_W'(samp[k]);
    end
  end

  assign s3_free  = !s3_valid || take;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  assign prod     = P_W'(s1_sum) * RECIP_V;
  assign est_next = prod[SUM_W +: LEVEL_W];

  always_comb begin
    scaled  = X_W'(s2_sum) * HUNDRED_V;
    est_inc = s2_est + 7'd1;
    bound   = X_W'(est_inc) * DIV_V;
    quot    = (bound <= scaled) ? est_inc : s2_est;
    if (quot <= LEVEL_W'(cfg.endstop_pct)) begin
      pct_next = '0;
    end else if ((8'(quot) + 8'(cfg.endstop_pct)) >= 8'(LEVEL_MAX)) begin
      pct_next = LEVEL_MAX;
    end else begin
      pct_next = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_channel <= item.channel;
      s1_now     <= item.now_ms;
      s1_sum     <= sum_next;
    end
    if (s2_free) begin
      s2_channel <= s1_channel;
      s2_now     <= s1_now;
      s2_sum     <= s1_sum;
      s2_est     <= est_next;
    end
    if (s3_free) begin
      s3_channel <= s2_channel;
      s3_now     <= s2_now;
      s3_pct     <= pct_next;
    end
  end

  assign stage.valid   = s3_valid;
  assign stage.channel = s3_channel;
  assign stage.now_ms  = s3_now;
  assign stage.pct     = s3_pct;

endmodule

`default_nettype wire

@@ rtl/flc_lane.sv @@
// One channel's hysteresis state and its move and emit decision.
// Depends on flc_pkg.
`default_nettype none

module flc_lane #(
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire flc_pkg::stage_t  stage,
  input  wire flc_pkg::cfg_t    cfg,
  input  wire logic            commit,
  output flc_pkg::lane_res_t    res
);
  import flc_pkg::*;

  logic [LEVEL_W-1:0] sent_level;
  logic               never_sent;
  logic [LEVEL_W-1:0] target_level;
  logic [TIME_W-1:0]  last_move_time;
  logic               pending;

  logic               hit;
  logic [LEVEL_W-1:0] diff;
  logic               moved;
  logic [TIME_W-1:0]  elapsed;
  logic               emit;

  always_comb begin
    hit     = stage.valid && (stage.channel == CH_W'(IDX));
    diff    = (stage.pct >= sent_level) ? (stage.pct - sent_level) : (sent_level - stage.pct);
    moved   = (never_sent && !pending) || (diff > cfg.deadzone_pct);
    elapsed = stage.now_ms - last_move_time;
    // A move restamps the time, so it can never be emitted in the same item.
    emit    = hit && !moved && pending && (elapsed > TIME_W'(cfg.quiet_ms));
  end

  assign res.emit  = emit;
  assign res.level = target_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_level     <= '0;
      never_sent     <= 1'b1;
      target_level   <= '0;
      last_move_time <= '0;
      pending        <= 1'b0;
    end else if (hit && commit) begin
      if (moved) begin
        target_level   <= stage.pct;
        last_move_time <= stage.now_ms;
        pending        <= 1'b1;
      end else if (emit) begin
        sent_level <= target_level;
        never_sent <= 1'b0;
        pending    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/fader_level_deadzone_coalescer.sv @@
// Fader level coalescer: averages a channel's ADC reads to a percent, applies
// endstop snapping, a deadzone around the last sent level and a quiet time
// before a settled level is reported. It takes one item per cycle while not
// stalled; an item passes the three scaling stages (sum, reciprocal multiply,
// correction and snap) and its result is then registered in the output
// register. Each channel has its own lane of state flops, so items of the
// same channel may follow each other without a gap. A held result stalls
// the pipeline only when the next item also produces a result.
// Depends on flc_pkg, flc_level and flc_lane.
`default_nettype none

module fader_level_deadzone_coalescer #(
  parameter int CHANNELS = flc_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = flc_pkg::SAMPLES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  sample_valid,
  output logic                                       sample_ready,
  input  wire flc_pkg::in_item_t                      samples,
  output logic                                       level_valid,
  input  wire logic                                  level_ready,
  output flc_pkg::out_item_t                          level,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [flc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [flc_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import flc_pkg::*;

  cfg_t      cfg;
  stage_t    stage;
  logic      take;
  logic      out_free;
  lane_res_t lane_res [CHANNELS];
  logic [CHANNELS-1:0] emit_vec;
  logic               any_emit;
  logic [LEVEL_W-1:0] merged_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone_pct <= DEADZONE_RST;
      cfg.endstop_pct  <= ENDSTOP_RST;
      cfg.quiet_ms     <= QUIET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADZONE: cfg.deadzone_pct <= cfg_data[DZ_W-1:0];
        REG_ENDSTOP:  cfg.endstop_pct  <= cfg_data[ES_W-1:0];
        REG_QUIET:    cfg.quiet_ms     <= cfg_data[QUIET_W-1:0];
        default: ;
      endcase
    end
  end

  flc_level #(
    .SAMPLES(SAMPLES)
  ) u_level (
    .clk     (clk),
    .rst     (rst),
    .in_valid(sample_valid),
    .in_ready(sample_ready),
    .item    (samples),
    .cfg     (cfg),
    .stage   (stage),
    .take    (take)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    flc_lane #(
      .IDX(c)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .stage (stage),
      .cfg   (cfg),
      .commit(take),
      .res   (lane_res[c])
    );
    assign emit_vec[c] = lane_res[c].emit;
  end

  // Only the lane that owns the item's channel can emit, so an OR merges them.
  always_comb begin
    merged_level = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      merged_level = merged_level | (lane_res[c].emit ? lane_res[c].level : '0);
    end
  end

  assign any_emit = |emit_vec;
  assign out_free = !level_valid || level_ready;
  assign take     = stage.valid && (!any_emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (out_free) begin
      level_valid <= stage.valid && any_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && any_emit) begin
      level.out_channel <= stage.channel;
      level.level_pct   <= merged_level;
    end
  end

  a_one_lane: assert property (@(posedge clk) disable iff (rst) $onehot0(emit_vec))
    else $error("more than one lane emitted for a single item");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
      level_valid |-> (level.level_pct <= LEVEL_MAX))
    else $error("reported level above full scale");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
      $rose(level_valid) |-> $past(stage.valid && any_emit))
    else $error("result appeared without an emitting item");

  a_emit_channel: assert property (@(posedge clk) disable iff (rst)
      any_emit |-> (32'(stage.channel) < CHANNELS))
    else $error("emit for a channel outside the configured range");

endmodule

`default_nettype wire
